// ===== rtl/core/pnp_pkg.sv =====
// ----------------------------------------------------------------------------
// pnp_pkg
// Shared types, character codes and helpers of the prefixed number parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pnp_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned OUT_BITS       = 32;
  localparam int unsigned CHAR_BITS      = 8;
  localparam int unsigned M_DATA_BITS    = 40;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_ZERO,
    PH_SIGN,
    PH_DIGITS,
    PH_STOPPED
  } phase_e;

  typedef enum logic [2:0] {
    RAD_NONE,
    RAD_BIN,
    RAD_OCT,
    RAD_DEC,
    RAD_HEX
  } radix_e;

  typedef struct packed {
    phase_e phase;
    radix_e radix;
    logic   negative;
    logic   clean_stop;
  } pnp_state_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic                well_formed;
  } pnp_result_t;

  localparam pnp_state_t STATE_RESET = '{
    phase:      PH_PREFIX,
    radix:      RAD_NONE,
    negative:   1'b0,
    clean_stop: 1'b1
  };

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_1       = 8'h31;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UC_A    = 8'h41;
  localparam logic [7:0] CH_UC_Z    = 8'h5a;
  localparam logic [7:0] CH_A       = 8'h61;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_E       = 8'h65;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_O       = 8'h6f;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CASE_SHIFT = 8'h20;

  localparam logic [4:0] NO_DIGIT   = 5'd16;
  localparam logic [4:0] HEX_LETTER = 5'd10;

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= CH_0 && c <= CH_9) begin
      d = 5'(c - CH_0);
    end else if (c >= CH_A && c <= CH_F) begin
      d = 5'(c - CH_A) + HEX_LETTER;
    end
    return d;
  endfunction

  function automatic logic is_stop(input logic [7:0] c);
    return (c == CH_COMMA) || (c == CH_MINUS) || (c == CH_PLUS) ||
           (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_SPACE) ||
           (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic digit_ok(input logic [4:0] d, input radix_e r);
    logic ok;
    case (r)
      RAD_BIN: ok = (d < 5'd2);
      RAD_OCT: ok = (d < 5'd8);
      RAD_DEC: ok = (d < 5'd10);
      RAD_HEX: ok = (d < 5'd16);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pnp_step.sv =====
// ----------------------------------------------------------------------------
// pnp_step
// Next-state and result logic for one string byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pnp_step #(
  parameter int unsigned VALUE_BITS = pnp_pkg::VALUE_BITS_DEF
) (
  input  wire logic [7:0]            char_i,
  input  wire logic                  default_hex_i,
  input  wire pnp_pkg::pnp_state_t   state_i,
  input  wire logic [VALUE_BITS-1:0] acc_i,
  output pnp_pkg::pnp_state_t        state_o,
  output logic [VALUE_BITS-1:0]      acc_o,
  output pnp_pkg::pnp_result_t       result_o
);

  logic [4:0]            digit;
  logic [7:0]            lc;
  logic                  is_dec;
  logic                  do_prefix;
  logic                  take;
  pnp_pkg::radix_e       def_radix;
  pnp_pkg::pnp_state_t   state_pre;
  logic [VALUE_BITS-1:0] acc_scaled;
  logic [VALUE_BITS-1:0] acc_next;
  logic [VALUE_BITS-1:0] signed_val;

  assign digit     = pnp_pkg::digit_of(char_i);
  assign is_dec    = (char_i >= pnp_pkg::CH_0) && (char_i <= pnp_pkg::CH_9);
  assign lc        = (char_i >= pnp_pkg::CH_UC_A && char_i <= pnp_pkg::CH_UC_Z) ?
                     char_i + pnp_pkg::CASE_SHIFT : char_i;
  assign def_radix = default_hex_i ? pnp_pkg::RAD_HEX : pnp_pkg::RAD_DEC;

  always_comb begin
    state_pre = state_i;
    do_prefix = 1'b0;
    take      = 1'b0;
    case (state_i.phase)
      pnp_pkg::PH_PREFIX: begin
        do_prefix = 1'b1;
      end
      pnp_pkg::PH_ZERO: begin
        if (is_dec) begin
          state_pre.radix = def_radix;
          state_pre.phase = pnp_pkg::PH_DIGITS;
          take            = 1'b1;
        end else begin
          do_prefix = 1'b1;
        end
      end
      pnp_pkg::PH_SIGN: begin
        state_pre.phase = pnp_pkg::PH_DIGITS;
        if (char_i == pnp_pkg::CH_MINUS) begin
          state_pre.negative = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      pnp_pkg::PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_prefix) begin
      case (lc) inside
        pnp_pkg::CH_PERCENT: begin
          state_pre.radix = pnp_pkg::RAD_BIN;
          state_pre.phase = pnp_pkg::PH_SIGN;
        end
        pnp_pkg::CH_O, pnp_pkg::CH_AMP: begin
          state_pre.radix = pnp_pkg::RAD_OCT;
          state_pre.phase = pnp_pkg::PH_SIGN;
        end
        pnp_pkg::CH_X, pnp_pkg::CH_DOLLAR: begin
          state_pre.radix = pnp_pkg::RAD_HEX;
          state_pre.phase = pnp_pkg::PH_SIGN;
        end
        pnp_pkg::CH_U, pnp_pkg::CH_I, pnp_pkg::CH_HASH: begin
          state_pre.radix = pnp_pkg::RAD_DEC;
          state_pre.phase = pnp_pkg::PH_SIGN;
        end
        pnp_pkg::CH_0: begin
          state_pre.phase = pnp_pkg::PH_ZERO;
        end
        [pnp_pkg::CH_1:pnp_pkg::CH_9]: begin
          state_pre.radix = def_radix;
          state_pre.phase = pnp_pkg::PH_DIGITS;
          take            = 1'b1;
        end
        pnp_pkg::CH_A, pnp_pkg::CH_C, pnp_pkg::CH_E, pnp_pkg::CH_F: begin
          if (default_hex_i) begin
            state_pre.radix = pnp_pkg::RAD_HEX;
            state_pre.phase = pnp_pkg::PH_DIGITS;
            take            = 1'b1;
          end else begin
            state_pre.clean_stop = 1'b0;
            state_pre.phase      = pnp_pkg::PH_STOPPED;
          end
        end
        pnp_pkg::CH_B, pnp_pkg::CH_D: begin
          if (default_hex_i) begin
            state_pre.radix = pnp_pkg::RAD_HEX;
            state_pre.phase = pnp_pkg::PH_DIGITS;
            take            = 1'b1;
          end else begin
            state_pre.radix = (lc == pnp_pkg::CH_B) ? pnp_pkg::RAD_BIN : pnp_pkg::RAD_DEC;
            state_pre.phase = pnp_pkg::PH_SIGN;
          end
        end
        default: begin
          state_pre.clean_stop = 1'b0;
          state_pre.phase      = pnp_pkg::PH_STOPPED;
        end
      endcase
    end
  end

  always_comb begin
    case (state_pre.radix)
      pnp_pkg::RAD_BIN: acc_scaled = acc_i << 1;
      pnp_pkg::RAD_OCT: acc_scaled = acc_i << 3;
      pnp_pkg::RAD_DEC: acc_scaled = (acc_i << 3) + (acc_i << 1);
      pnp_pkg::RAD_HEX: acc_scaled = acc_i << 4;
      default:          acc_scaled = '0;
    endcase
    acc_next = acc_scaled + {{(VALUE_BITS-4){1'b0}}, digit[3:0]};
  end

  always_comb begin
    state_o = state_pre;
    acc_o   = acc_i;
    if (take) begin
      if (pnp_pkg::digit_ok(digit, state_pre.radix)) begin
        acc_o = acc_next;
      end else begin
        state_o.clean_stop = pnp_pkg::is_stop(char_i);
        state_o.phase      = pnp_pkg::PH_STOPPED;
      end
    end
    if (char_i == pnp_pkg::CH_NUL) begin
      state_o = pnp_pkg::STATE_RESET;
      acc_o   = '0;
    end
  end

  assign signed_val = state_i.negative ? (~acc_i + VALUE_BITS'(1)) : acc_i;

  generate
    if (VALUE_BITS >= pnp_pkg::OUT_BITS) begin : g_wide
      always_comb begin
        result_o.value = signed_val[pnp_pkg::OUT_BITS-1:0];
        if (state_i.phase == pnp_pkg::PH_PREFIX || state_i.phase == pnp_pkg::PH_ZERO) begin
          result_o.value = '0;
        end
      end
    end else begin : g_narrow
      always_comb begin
        result_o.value = {{(pnp_pkg::OUT_BITS-VALUE_BITS){signed_val[VALUE_BITS-1]}},
                          signed_val};
        if (state_i.phase == pnp_pkg::PH_PREFIX || state_i.phase == pnp_pkg::PH_ZERO) begin
          result_o.value = '0;
        end
      end
    end
  endgenerate

  always_comb begin
    case (state_i.phase)
      pnp_pkg::PH_PREFIX: result_o.well_formed = 1'b0;
      pnp_pkg::PH_ZERO:   result_o.well_formed = 1'b1;
      default:            result_o.well_formed = state_i.clean_stop;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/pnp_out_stage.sv =====
// ----------------------------------------------------------------------------
// pnp_out_stage
// Result register feeding the master-side stream.
// ----------------------------------------------------------------------------
`default_nettype none

module pnp_out_stage (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire pnp_pkg::pnp_result_t            result_i,
  output logic                                 load_ok_o,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [pnp_pkg::M_DATA_BITS-1:0]      m_tdata
);

  logic                 valid_q, valid_d;
  pnp_pkg::pnp_result_t res_q, res_d;

  assign load_ok_o = !valid_q || m_tready;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = result_i;
    end else if (m_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_tvalid = valid_q;
  assign m_tdata  = {{(pnp_pkg::M_DATA_BITS - pnp_pkg::OUT_BITS - 1){1'b0}},
                     res_q.well_formed, res_q.value};

endmodule

`default_nettype wire

// ===== rtl/core/prefixed_number_parser.sv =====
// ----------------------------------------------------------------------------
// prefixed_number_parser
// Radix-prefixed integer parser: one string byte per request, one result
// (signed value and well-formed flag) per terminating NUL.
//
// channel   direction  fields (lowest bit first)
// s_*       in         tdata: char_in[7:0]
// m_*       out        tdata: value[31:0], well_formed[32], zero pad[39:33]
// cfg_*     in         wdata: default_hex
//
// One byte per cycle while no NUL is held back; a byte is registered in the
// input register and updates the parse state as it leaves, and a leaving NUL
// also loads its result into the result register that drives m_*. Reset
// clears all parse state and default_hex. A NUL waits in the input register
// while the result register is full and not taken, stalling s_* for that time.
// ----------------------------------------------------------------------------
`default_nettype none

module prefixed_number_parser #(
  parameter int unsigned VALUE_BITS = pnp_pkg::VALUE_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,   // char_in[7:0]
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [pnp_pkg::M_DATA_BITS-1:0]     m_tdata,   // value[31:0], well_formed[32]
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_wdata_i
);

  logic                  in_valid_q, in_valid_d;
  logic [7:0]            char_q;
  logic                  default_hex_q;
  pnp_pkg::pnp_state_t   state_q, state_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  pnp_pkg::pnp_result_t  result;
  logic                  is_nul;
  logic                  load_ok;
  logic                  advance;
  logic                  emit;
  logic                  accept;

  assign is_nul   = (char_q == pnp_pkg::CH_NUL);
  assign advance  = in_valid_q && (!is_nul || load_ok);
  assign emit     = advance && is_nul;
  assign s_tready = !in_valid_q || advance;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      default_hex_q <= 1'b0;
      state_q       <= pnp_pkg::STATE_RESET;
      acc_q         <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        default_hex_q <= cfg_wdata_i;
      end
      if (advance) begin
        state_q <= state_d;
        acc_q   <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= s_tdata;
    end
  end

  pnp_step #(
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .char_i        (char_q),
    .default_hex_i (default_hex_q),
    .state_i       (state_q),
    .acc_i         (acc_q),
    .state_o       (state_d),
    .acc_o         (acc_d),
    .result_o      (result)
  );

  pnp_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (emit),
    .result_i  (result),
    .load_ok_o (load_ok),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  a_nul_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (state_q.phase == pnp_pkg::PH_PREFIX) && (acc_q == '0) && !state_q.negative)
    else $error("parse state not cleared after end of string");

  a_prefix_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == pnp_pkg::PH_PREFIX || state_q.phase == pnp_pkg::PH_ZERO)
      |-> (acc_q == '0) && !state_q.negative)
    else $error("accumulator holds digits before the radix is settled");

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken result");

  a_held_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(char_q))
    else $error("stalled byte lost from the input register");

endmodule

`default_nettype wire

// ===== bench/prefixed_number_parser_tb.sv =====
// ----------------------------------------------------------------------------
// prefixed_number_parser_tb
// Streams NUL-terminated strings into the parser one byte per request. A
// scoreboard holds its own model of the parse state and queues the expected
// value and well-formed flag for every NUL. Each result is checked against
// the oldest entry in that queue. The run covers directed corner strings,
// then random prefixed numbers, noise and broken strings under both
// default_hex settings. Both sides idle at random, one phase runs with no
// idling at all, and in one phase the result side holds off long enough to
// stall the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prefixed_number_parser_tb;

  localparam int unsigned HALF_PERIOD   = 10;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_BYTES   = 260;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned OUT_BITS      = pnp_pkg::OUT_BITS;
  localparam int unsigned M_DATA_BITS   = pnp_pkg::M_DATA_BITS;

  typedef struct {
    logic [OUT_BITS-1:0] value;
    logic                well_formed;
  } parse_result_t;

  class parse_scoreboard;
    bit                  default_hex;
    pnp_pkg::phase_e     phase = pnp_pkg::PH_PREFIX;
    logic [4:0]          radix;
    bit                  negative;
    logic [OUT_BITS-1:0] accumulator;
    bit                  clean_stop = 1'b1;
    parse_result_t       expected_q[$];
    int unsigned         errors;
    int unsigned         checked;

    function void clear_string();
      phase       = pnp_pkg::PH_PREFIX;
      radix       = 5'd0;
      negative    = 1'b0;
      accumulator = '0;
      clean_stop  = 1'b1;
    endfunction

    function logic [4:0] weight_of(logic [7:0] c);
      if (c >= pnp_pkg::CH_0 && c <= pnp_pkg::CH_9) return 5'(c - pnp_pkg::CH_0);
      if (c >= pnp_pkg::CH_A && c <= pnp_pkg::CH_F) return 5'(c - pnp_pkg::CH_A) + 5'd10;
      return 5'd16;
    endfunction

    function bit ends_cleanly(logic [7:0] c);
      return c == pnp_pkg::CH_COMMA || c == pnp_pkg::CH_MINUS ||
             c == pnp_pkg::CH_PLUS || c == pnp_pkg::CH_LPAREN ||
             c == pnp_pkg::CH_RPAREN || c == pnp_pkg::CH_SPACE ||
             (c >= pnp_pkg::CH_TAB && c <= pnp_pkg::CH_CR);
    endfunction

    function void take_digit(logic [7:0] c);
      logic [4:0] w;
      w = weight_of(c);
      if (w < radix) begin
        accumulator = accumulator * OUT_BITS'(radix) + OUT_BITS'(w);
      end else begin
        clean_stop = ends_cleanly(c);
        phase      = pnp_pkg::PH_STOPPED;
      end
    endfunction

    function void start_digits(logic [4:0] r, logic [7:0] c);
      radix = r;
      phase = pnp_pkg::PH_DIGITS;
      take_digit(c);
    endfunction

    function void take_prefix(logic [7:0] c);
      logic [7:0] lc;
      lc = (c >= pnp_pkg::CH_UC_A && c <= pnp_pkg::CH_UC_Z) ? c + pnp_pkg::CASE_SHIFT : c;
      case (lc)
        pnp_pkg::CH_PERCENT: begin
          radix = 5'd2;
          phase = pnp_pkg::PH_SIGN;
        end
        pnp_pkg::CH_O, pnp_pkg::CH_AMP: begin
          radix = 5'd8;
          phase = pnp_pkg::PH_SIGN;
        end
        pnp_pkg::CH_X, pnp_pkg::CH_DOLLAR: begin
          radix = 5'd16;
          phase = pnp_pkg::PH_SIGN;
        end
        pnp_pkg::CH_U, pnp_pkg::CH_I, pnp_pkg::CH_HASH: begin
          radix = 5'd10;
          phase = pnp_pkg::PH_SIGN;
        end
        pnp_pkg::CH_0: phase = pnp_pkg::PH_ZERO;
        pnp_pkg::CH_A, pnp_pkg::CH_C, pnp_pkg::CH_E, pnp_pkg::CH_F: begin
          if (default_hex) begin
            start_digits(5'd16, c);
          end else begin
            clean_stop = 1'b0;
            phase      = pnp_pkg::PH_STOPPED;
          end
        end
        pnp_pkg::CH_B, pnp_pkg::CH_D: begin
          if (default_hex) begin
            start_digits(5'd16, c);
          end else begin
            radix = (lc == pnp_pkg::CH_B) ? 5'd2 : 5'd10;
            phase = pnp_pkg::PH_SIGN;
          end
        end
        default: begin
          if (lc >= pnp_pkg::CH_1 && lc <= pnp_pkg::CH_9) begin
            start_digits(default_hex ? 5'd16 : 5'd10, c);
          end else begin
            clean_stop = 1'b0;
            phase      = pnp_pkg::PH_STOPPED;
          end
        end
      endcase
    endfunction

    function void note_request(logic [7:0] c);
      parse_result_t r;
      if (c == pnp_pkg::CH_NUL) begin
        if (phase == pnp_pkg::PH_PREFIX) begin
          r.value       = '0;
          r.well_formed = 1'b0;
        end else if (phase == pnp_pkg::PH_ZERO) begin
          r.value       = '0;
          r.well_formed = 1'b1;
        end else begin
          r.value       = negative ? -accumulator : accumulator;
          r.well_formed = clean_stop;
        end
        expected_q.push_back(r);
        clear_string();
      end else begin
        case (phase)
          pnp_pkg::PH_PREFIX: take_prefix(c);
          pnp_pkg::PH_ZERO: begin
            if (c >= pnp_pkg::CH_0 && c <= pnp_pkg::CH_9) begin
              start_digits(default_hex ? 5'd16 : 5'd10, c);
            end else begin
              phase = pnp_pkg::PH_PREFIX;
              take_prefix(c);
            end
          end
          pnp_pkg::PH_SIGN: begin
            phase = pnp_pkg::PH_DIGITS;
            if (c == pnp_pkg::CH_MINUS) negative = 1'b1;
            else take_digit(c);
          end
          pnp_pkg::PH_DIGITS: take_digit(c);
          default: ;
        endcase
      end
    endfunction

    function void check_result(logic [M_DATA_BITS-1:0] beat);
      parse_result_t r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result with none pending: value %h well_formed %b",
                   beat[31:0], beat[32]);
        end
      end else begin
        r = expected_q.pop_front();
        checked++;
        if (beat[31:0] !== r.value || beat[32] !== r.well_formed) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR: result %0d: value %h well_formed %b, wanted %h %b",
                     checked, beat[31:0], beat[32], r.value, r.well_formed);
          end
        end
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_DATA_BITS-1:0] m_tdata;
  logic                   cfg_we_i;
  logic                   cfg_wdata_i;

  parse_scoreboard sb = new;
  logic [7:0]      text_q[$];
  bit              calm;
  int unsigned     hold_cycles;
  int unsigned     bytes_sent;
  int unsigned     cycle_count;

  prefixed_number_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) sb.note_request(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned idle_draw();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [7:0] digit_char(int unsigned w);
    return (w < 10) ? pnp_pkg::CH_0 + 8'(w) : pnp_pkg::CH_A + 8'(w - 10);
  endfunction

  function automatic logic [7:0] any_case(logic [7:0] c);
    return $urandom_range(0, 1) ? c - pnp_pkg::CASE_SHIFT : c;
  endfunction

  function automatic logic [7:0] stop_char();
    int unsigned k;
    k = $urandom_range(0, 10);
    case (k)
      0: return pnp_pkg::CH_COMMA;
      1: return pnp_pkg::CH_MINUS;
      2: return pnp_pkg::CH_PLUS;
      3: return pnp_pkg::CH_LPAREN;
      4: return pnp_pkg::CH_RPAREN;
      5: return pnp_pkg::CH_SPACE;
      default: return pnp_pkg::CH_TAB + 8'(k - 6);
    endcase
  endfunction

  function automatic void push_junk();
    repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(1, 255)));
  endfunction

  function automatic void build_random_string();
    int unsigned r;
    int unsigned n;
    int unsigned pick;
    int unsigned tail;
    text_q.delete();
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(1, 255)));
      return;
    end
    r    = sb.default_hex ? 16 : 10;
    pick = $urandom_range(0, 11);
    case (pick)
      0: begin
        text_q.push_back(pnp_pkg::CH_PERCENT);
        r = 2;
      end
      1: begin
        text_q.push_back($urandom_range(0, 1) ? any_case(pnp_pkg::CH_O) : pnp_pkg::CH_AMP);
        r = 8;
      end
      2: begin
        text_q.push_back($urandom_range(0, 1) ? any_case(pnp_pkg::CH_X) : pnp_pkg::CH_DOLLAR);
        r = 16;
      end
      3: begin
        case ($urandom_range(0, 2))
          0: text_q.push_back(any_case(pnp_pkg::CH_U));
          1: text_q.push_back(any_case(pnp_pkg::CH_I));
          default: text_q.push_back(pnp_pkg::CH_HASH);
        endcase
        r = 10;
      end
      4: begin
        text_q.push_back(any_case(pnp_pkg::CH_B));
        r = 2;
      end
      5: begin
        text_q.push_back(any_case(pnp_pkg::CH_D));
        r = 10;
      end
      6: begin
        text_q.push_back(pnp_pkg::CH_0);
        text_q.push_back(pnp_pkg::CH_X);
        r = 16;
      end
      7: begin
        text_q.push_back(pnp_pkg::CH_0);
        text_q.push_back(pnp_pkg::CH_PERCENT);
        r = 2;
      end
      default: ;
    endcase
    if (pick < 8 && $urandom_range(0, 3) == 0) text_q.push_back(pnp_pkg::CH_MINUS);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    repeat (n) text_q.push_back(digit_char($urandom_range(0, r - 1)));
    tail = $urandom_range(0, 99);
    if (tail < 25) begin
      text_q.push_back(stop_char());
      push_junk();
    end else if (tail < 40) begin
      text_q.push_back(8'($urandom_range(1, 255)));
      push_junk();
    end else if (tail < 48) begin
      text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(1, 255)));
    end
  endfunction

  task automatic send_byte(input logic [7:0] c);
    int unsigned gap;
    gap = idle_draw();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]));
    send_byte(pnp_pkg::CH_NUL);
  endtask

  task automatic send_built_string();
    foreach (text_q[i]) send_byte(text_q[i]);
    send_byte(pnp_pkg::CH_NUL);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_default_hex(input bit v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.default_hex = v;
  endtask

  initial begin : result_sink
    int unsigned stall;
    m_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = idle_draw();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned target;
    rst_ni      <= 1'b0;
    s_tvalid    <= 1'b0;
    s_tdata     <= pnp_pkg::CH_NUL;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("");
    send_text("0");
    send_text("%-101");
    send_text("0$ff,");
    send_text("o7G");
    send_byte(8'hff);
    send_text("5");
    send_text("x");

    for (int ph = 0; ph < 5; ph++) begin
      write_default_hex(ph % 2 == 0);
      calm = (ph == 1);
      if (ph == 3) hold_cycles = HOLD_CYCLES;
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        build_random_string();
        send_built_string();
      end
    end
    calm = 1'b0;

    drain_results();
    sb.errors += sb.expected_q.size();
    $display("%0d bytes sent, %0d results checked, %0d errors", bytes_sent, sb.checked,
             sb.errors);
    $display("default_hex 0 and 1, one phase without idling, one %0d-cycle hold-off",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== prefixed_number_parser.f =====
rtl/core/pnp_pkg.sv
rtl/core/pnp_step.sv
rtl/core/pnp_out_stage.sv
rtl/core/prefixed_number_parser.sv
bench/prefixed_number_parser_tb.sv
